// ----- hdl/bcu_pkg.sv -----
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types and fixed constants of the barycentric coordinates unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

	// result weights are always 32-bit signed fixed point
	localparam int WEIGHT_W   = 32;
	localparam int NUM_COORDS = 12;
	localparam int NUM_DOTS   = 5;
	localparam int NUM_PRODS  = 6;
	localparam int NUM_LANES  = 2;

	// control that travels alongside the pipeline data
	typedef struct packed {
		logic valid;
		logic degen;
	} stage_ctrl_t;

endpackage

// ----- hdl/barycentric_coordinates_unit.sv -----
// Path: bcu_dot, bcu_cramer, then bcu_solve with its one-bit-per-stage divider,
// and last the output register.
// Throughput: one transaction per cycle, sustained; a stalled output is held
// with one skid entry, and the whole pipeline freezes while that entry is full.
// Reset: arst_n asynchronously clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// barycentric_coordinates_unit
// Barycentric weights of a point in a triangle by Cramer's rule, Q15.16 out.
// ----------------------------------------------------------------------------
module barycentric_coordinates_unit #(
	parameter int COORD_WIDTH      = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              s_tvalid,
	output logic                                              s_tready,
	// ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz
	input  logic [((bcu_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                                              m_tvalid,
	input  logic                                              m_tready,
	// weight_a, weight_b, weight_c
	output logic [3*bcu_pkg::WEIGHT_W-1:0]                    m_tdata,
	// degenerate
	output logic                                              m_tuser
);
	import bcu_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = 2 * W + 3;
	localparam int NW = 4 * W + 6;
	localparam int MW = 4 * W + 5;
	localparam int OW = 3 * WEIGHT_W;

	logic                       en;
	logic                       dot_vld;
	logic [NUM_DOTS*DW-1:0]     dots;
	stage_ctrl_t                cr_ctrl, sv_ctrl;
	logic [MW-1:0]              den;
	logic signed [NW-1:0]       num_b, num_c;
	logic [OW-1:0]              weights;

	logic                       out_vld_q, skid_vld_q;
	logic [OW-1:0]              out_data_q, skid_data_q;
	logic                       out_deg_q, skid_deg_q;

	// pipeline advances while the skid entry is free
	assign en       = ~skid_vld_q;
	assign s_tready = en;

	bcu_dot #(.COORD_WIDTH(W)) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_coords(s_tdata[NUM_COORDS*W-1:0]),
		.out_valid(dot_vld),
		.dots     (dots)
	);

	bcu_cramer #(.COORD_WIDTH(W)) u_cramer (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(dot_vld),
		.dots    (dots),
		.ctrl    (cr_ctrl),
		.den     (den),
		.num_b   (num_b),
		.num_c   (num_c)
	);

	bcu_solve #(.COORD_WIDTH(W), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_solve (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctrl (cr_ctrl),
		.den     (den),
		.num_b   (num_b),
		.num_c   (num_c),
		.out_ctrl(sv_ctrl),
		.weights (weights)
	);

	// output register and skid entry, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (sv_ctrl.valid && out_vld_q && !m_tready) skid_vld_q <= 1'b1;
			if (!out_vld_q || m_tready) out_vld_q <= sv_ctrl.valid;
		end else if (m_tready) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end
	end

	// output register and skid entry, payload
	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_vld_q || m_tready) begin
				out_data_q <= weights;
				out_deg_q  <= sv_ctrl.degen;
			end else begin
				skid_data_q <= weights;
				skid_deg_q  <= sv_ctrl.degen;
			end
		end else if (m_tready) begin
			out_data_q <= skid_data_q;
			out_deg_q  <= skid_deg_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_deg_q;

endmodule

// ----- hdl/bcu_dot.sv -----
// ----------------------------------------------------------------------------
// bcu_dot
// Edge vectors and the five dot products, three register stages.
// ----------------------------------------------------------------------------
module bcu_dot #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       in_valid,
	input  logic [bcu_pkg::NUM_COORDS*COORD_WIDTH-1:0] in_coords,
	output logic                                       out_valid,
	// d00, d11, d01, d20, d21 from the lowest bits up
	output logic [bcu_pkg::NUM_DOTS*(2*COORD_WIDTH+3)-1:0] dots
);
	import bcu_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int VW = W + 1;
	localparam int PW = 2 * VW;
	localparam int DW = 2 * W + 3;

	logic signed [W-1:0]  crd [NUM_COORDS];
	logic signed [VW-1:0] vec_s1 [9];
	logic signed [PW-1:0] prod_s2 [15];
	logic signed [DW-1:0] dot_s3 [NUM_DOTS];
	logic                 vld_s1, vld_s2, vld_s3;

	for (genvar i = 0; i < NUM_COORDS; i++) begin : g_crd
		assign crd[i] = in_coords[i*W +: W];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: v0 = B-A, v1 = C-A, v2 = P-A
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				vec_s1[k]   <= VW'(crd[3+k]) - VW'(crd[k]);
				vec_s1[3+k] <= VW'(crd[6+k]) - VW'(crd[k]);
				vec_s1[6+k] <= VW'(crd[9+k]) - VW'(crd[k]);
			end
		end
	end

	// stage 2: per-axis products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[k]    <= PW'(vec_s1[k])   * PW'(vec_s1[k]);
				prod_s2[3+k]  <= PW'(vec_s1[3+k]) * PW'(vec_s1[3+k]);
				prod_s2[6+k]  <= PW'(vec_s1[k])   * PW'(vec_s1[3+k]);
				prod_s2[9+k]  <= PW'(vec_s1[6+k]) * PW'(vec_s1[k]);
				prod_s2[12+k] <= PW'(vec_s1[6+k]) * PW'(vec_s1[3+k]);
			end
		end
	end

	// stage 3: sum the three axes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NUM_DOTS; j++) begin
				dot_s3[j] <= DW'(prod_s2[3*j]) + DW'(prod_s2[3*j+1]) + DW'(prod_s2[3*j+2]);
			end
		end
	end

	for (genvar j = 0; j < NUM_DOTS; j++) begin : g_out
		assign dots[j*DW +: DW] = dot_s3[j];
	end
	assign out_valid = vld_s3;

endmodule

// ----- hdl/bcu_cramer.sv -----
// ----------------------------------------------------------------------------
// bcu_cramer
// Determinant and the two Cramer numerators, split multipliers, three stages.
// ----------------------------------------------------------------------------
module bcu_cramer #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           in_valid,
	input  logic [bcu_pkg::NUM_DOTS*(2*COORD_WIDTH+3)-1:0] dots,
	output bcu_pkg::stage_ctrl_t                           ctrl,
	output logic [4*COORD_WIDTH+4:0]                       den,
	output logic signed [4*COORD_WIDTH+5:0]                num_b,
	output logic signed [4*COORD_WIDTH+5:0]                num_c
);
	import bcu_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = 2 * W + 3;
	localparam int H  = (DW + 1) / 2;   // unsigned low half
	localparam int HW = DW - H;         // signed high half
	localparam int NW = 4 * W + 6;
	localparam int MW = 4 * W + 5;

	// operand pairs: d00*d11, d01*d01, d20*d11, d01*d21, d00*d21, d20*d01
	localparam int OPA [NUM_PRODS] = '{0, 2, 3, 2, 0, 3};
	localparam int OPB [NUM_PRODS] = '{1, 2, 1, 4, 4, 2};

	logic signed [DW-1:0]     dot [NUM_DOTS];
	logic signed [2*HW-1:0]   hh_s1 [NUM_PRODS];
	logic signed [HW+H:0]     hl_s1 [NUM_PRODS];
	logic signed [HW+H:0]     lh_s1 [NUM_PRODS];
	logic        [2*H-1:0]    ll_s1 [NUM_PRODS];
	logic signed [NW-1:0]     prod_s2 [NUM_PRODS];
	logic        [MW-1:0]     den_s3;
	logic signed [NW-1:0]     nb_s3, nc_s3;
	logic signed [NW-1:0]     den_full;
	stage_ctrl_t              ctl_s1, ctl_s2, ctl_s3;

	for (genvar j = 0; j < NUM_DOTS; j++) begin : g_dot
		assign dot[j] = dots[j*DW +: DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: in_valid, degen: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= '{valid: ctl_s2.valid, degen: (den_full == '0)};
		end
	end

	// stage 1: partial products of the split operands
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < NUM_PRODS; m++) begin
				hh_s1[m] <= $signed(dot[OPA[m]][DW-1:H]) * $signed(dot[OPB[m]][DW-1:H]);
				hl_s1[m] <= $signed(dot[OPA[m]][DW-1:H]) * $signed({1'b0, dot[OPB[m]][H-1:0]});
				lh_s1[m] <= $signed({1'b0, dot[OPA[m]][H-1:0]}) * $signed(dot[OPB[m]][DW-1:H]);
				ll_s1[m] <= dot[OPA[m]][H-1:0] * dot[OPB[m]][H-1:0];
			end
		end
	end

	// stage 2: recombine partials
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < NUM_PRODS; m++) begin
				prod_s2[m] <= (NW'(hh_s1[m]) << (2*H)) + (NW'(hl_s1[m]) << H)
					+ (NW'(lh_s1[m]) << H) + NW'(ll_s1[m]);
			end
		end
	end

	// stage 3: determinant and numerators
	assign den_full = prod_s2[0] - prod_s2[1];

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= den_full[MW-1:0];
			nb_s3  <= prod_s2[2] - prod_s2[3];
			nc_s3  <= prod_s2[4] - prod_s2[5];
		end
	end

	assign ctrl  = ctl_s3;
	assign den   = den_s3;
	assign num_b = nb_s3;
	assign num_c = nc_s3;

endmodule

// ----- hdl/bcu_solve.sv -----
// ----------------------------------------------------------------------------
// bcu_solve
// Pipelined restoring division of both numerators, rounding, w_a, clamp, degen zeroing.
// ----------------------------------------------------------------------------
module bcu_solve #(
	parameter int COORD_WIDTH      = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  bcu_pkg::stage_ctrl_t                 in_ctrl,
	input  logic [4*COORD_WIDTH+4:0]             den,
	input  logic signed [4*COORD_WIDTH+5:0]      num_b,
	input  logic signed [4*COORD_WIDTH+5:0]      num_c,
	output bcu_pkg::stage_ctrl_t                 out_ctrl,
	// weight_a, weight_b, weight_c from the lowest bits up
	output logic [3*bcu_pkg::WEIGHT_W-1:0]       weights
);
	import bcu_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int NW = 4 * W + 6;
	localparam int MW = 4 * W + 5;
	localparam int QW = MW + F;
	localparam int SW = QW + 4;

	localparam logic signed [SW-1:0] ONE_FX = SW'(1) <<< F;
	localparam logic signed [SW-1:0] SAT_HI = SW'(2147483647);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	logic signed [NW-1:0] num [NUM_LANES];

	// division pipeline, index 0 is the operand prep stage
	logic [MW-1:0] rem_s  [QW+1][NUM_LANES];
	logic [QW-1:0] quo_s  [QW+1][NUM_LANES];
	logic          neg_s  [QW+1][NUM_LANES];
	logic [MW-1:0] den_s  [QW+1];
	stage_ctrl_t   ctl_s  [QW+1];

	logic signed [QW+1:0] q_r [NUM_LANES];
	stage_ctrl_t          ctl_r;
	logic [WEIGHT_W-1:0]  w_f [3];
	stage_ctrl_t          ctl_f;

	logic signed [SW-1:0] qa_full;

	function automatic logic [WEIGHT_W-1:0] sat_w(input logic signed [SW-1:0] v);
		if (v > SAT_HI)
			return {1'b0, {(WEIGHT_W-1){1'b1}}};
		else if (v < SAT_LO)
			return {1'b1, {(WEIGHT_W-1){1'b0}}};
		else
			return v[WEIGHT_W-1:0];
	endfunction

	assign num[0] = num_b;
	assign num[1] = num_c;

	// control through the division stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) ctl_s[k] <= '0;
			ctl_r <= '0;
			ctl_f <= '0;
		end else if (en) begin
			ctl_s[0] <= in_ctrl;
			for (int k = 1; k <= QW; k++) ctl_s[k] <= ctl_s[k-1];
			ctl_r <= ctl_s[QW];
			ctl_f <= ctl_r;
		end
	end

	// prep: magnitude and sign, dividend scaled by the fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den[MW-1:0];
			for (int l = 0; l < NUM_LANES; l++) begin
				neg_s[0][l] <= num[l][NW-1];
				rem_s[0][l] <= '0;
				quo_s[0][l] <= num[l][NW-1] ? {MW'(-num[l]), {F{1'b0}}}
				                            : {MW'(num[l]), {F{1'b0}}};
			end
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [MW:0] rsh [NUM_LANES];
		logic        ge  [NUM_LANES];

		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			assign rsh[l] = {rem_s[k-1][l], quo_s[k-1][l][QW-1]};
			assign ge[l]  = (rsh[l] >= {1'b0, den_s[k-1]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_s[k-1];
				for (int l = 0; l < NUM_LANES; l++) begin
					neg_s[k][l] <= neg_s[k-1][l];
					rem_s[k][l] <= ge[l] ? MW'(rsh[l] - {1'b0, den_s[k-1]}) : rsh[l][MW-1:0];
					quo_s[k][l] <= {quo_s[k-1][l][QW-2:0], ge[l]};
				end
			end
		end
	end

	// round half away from zero, then restore the sign
	always_ff @(posedge clk) begin
		logic [QW:0] qr;
		if (en) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				qr = {1'b0, quo_s[QW][l]}
					+ (QW+1)'({rem_s[QW][l], 1'b0} >= {1'b0, den_s[QW]});
				q_r[l] <= neg_s[QW][l] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
			end
		end
	end

	// w_a from the unclamped weights, then clamp all three; all three are zero if degenerate
	assign qa_full = ONE_FX - SW'(q_r[0]) - SW'(q_r[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_r.degen) begin
				for (int i = 0; i < 3; i++) w_f[i] <= '0;
			end else begin
				w_f[0] <= sat_w(qa_full);
				w_f[1] <= sat_w(SW'(q_r[0]));
				w_f[2] <= sat_w(SW'(q_r[1]));
			end
		end
	end

	assign out_ctrl = ctl_f;
	assign weights  = {w_f[2], w_f[1], w_f[0]};

endmodule

// ----- hdl/bcu_checker.sv -----
// ----------------------------------------------------------------------------
// bcu_checker
// Port-level checks of the barycentric coordinates unit, bound to the top.
// ----------------------------------------------------------------------------
module bcu_checker #(
	parameter int COORD_WIDTH      = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input logic                                                 clk,
	input logic                                                 arst_n,
	input logic                                                 s_tvalid,
	input logic                                                 s_tready,
	input logic [((bcu_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input logic                                                 m_tvalid,
	input logic                                                 m_tready,
	input logic [3*bcu_pkg::WEIGHT_W-1:0]                       m_tdata,
	input logic                                                 m_tuser
);
	import bcu_pkg::*;

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// degenerate triangle gives zero weights
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate result with non-zero weights");

	// input is only held off while a result waits
	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// an empty output frees the skid entry by the next cycle
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |=> s_tready)
		else $error("input not ready after output drained");

endmodule

bind barycentric_coordinates_unit bcu_checker #(
	.COORD_WIDTH     (COORD_WIDTH),
	.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
) u_bcu_checker (.*);
